@@ hw/rtl/ecvt_pkg.sv @@
// ----------------------------------------------------------------------------
// ecvt_pkg: shared types and constants for the elliptic cone view test
// Field widths, register indexes, verdict codes, pipeline stage map and the
// configuration bundle handed from the register file to the datapath.
// ----------------------------------------------------------------------------
package ecvt_pkg;

  // Coordinate width default (ports follow the top-level parameter)
  localparam int COORD_BITS_DEF = 24;

  // Axis vectors: three signed Q1.14 lanes packed x low to z high
  localparam int AXIS_W    = 48;
  localparam int LANE_W    = 16;
  localparam int AXIS_FRAC = 14;
  localparam logic [LANE_W-1:0] AXIS_ONE = LANE_W'(1 << AXIS_FRAC);

  // Range (unsigned, in coordinate units) and squared tangents (unsigned Q8.16)
  localparam int RANGE_W  = 23;
  localparam int TAN_W    = 24;
  localparam int TAN_FRAC = 16;
  localparam logic [TAN_W-1:0] TAN_ONE = TAN_W'(1 << TAN_FRAC);

  // Derived configuration words
  localparam int R2_W   = 2 * RANGE_W;
  localparam int THTV_W = 2 * TAN_W;

  // Register reset values
  localparam logic [AXIS_W-1:0] FORWARD_RST = {{(2*LANE_W){1'b0}}, AXIS_ONE};
  localparam logic [AXIS_W-1:0] UP_RST      = {{LANE_W{1'b0}}, AXIS_ONE, {LANE_W{1'b0}}};
  localparam logic [AXIS_W-1:0] RIGHT_RST   = {AXIS_ONE, {(2*LANE_W){1'b0}}};

  // Register indexes on the write port
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_FORWARD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAN_H   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TAN_V   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FULL    = 3'd6;

  // Multiplier slicing: piece width in bits, register stages per unit
  localparam int PIECE_W = 32;
  localparam int MUL_STG = 3;

  // Pipeline stage map
  localparam int ST_DIFF     = 0;
  localparam int ST_PROD     = 1;
  localparam int ST_SUM      = 2;
  localparam int ST_MAG      = 3;
  localparam int ST_SQ       = 4;
  localparam int ST_PR       = ST_SQ + MUL_STG;
  localparam int ST_OUT      = ST_PR + MUL_STG;
  localparam int PIPE_STAGES = ST_OUT + 1;

  typedef enum logic [2:0] {
    VERDICT_INSIDE  = 3'd0,
    VERDICT_INVALID = 3'd1,
    VERDICT_RANGE   = 3'd2,
    VERDICT_BEHIND  = 3'd3,
    VERDICT_CONE    = 3'd4
  } verdict_t;

  // Configuration bundle, raw registers plus precomputed terms
  typedef struct packed {
    logic [AXIS_W-1:0]  fwd;
    logic [AXIS_W-1:0]  up;
    logic [AXIS_W-1:0]  rgt;
    logic [RANGE_W-1:0] max_range;
    logic [TAN_W-1:0]   th;
    logic [TAN_W-1:0]   tv;
    logic               full;
    logic [R2_W-1:0]    r2;
    logic [THTV_W-1:0]  thtv;
    logic               bad;
  } cfg_t;

  // Early decisions carried down the multiplier chain
  typedef struct packed {
    logic oor;
    logic behind;
  } flag_t;

  // One signed lane of a packed axis vector
  function automatic logic signed [LANE_W-1:0] axis_lane(input logic [AXIS_W-1:0] vec,
                                                         input int k);
    return vec[k*LANE_W +: LANE_W];
  endfunction

endpackage

@@ hw/rtl/elliptic_cone_view_test.sv @@
// ----------------------------------------------------------------------------
// elliptic_cone_view_test: elliptical cone field-of-view test
// Depth: 11 register stages. The squaring and the scaling by the tangents
// run as two banks of 3-stage sliced multipliers in series, which make up
// most of this depth.
// Throughput: one word per cycle; the input stalls only when every stage
// holds a word and the output is stalled.
// Reset (synchronous, rst_n low): pipeline emptied, registers to defaults.
// ----------------------------------------------------------------------------
module elliptic_cone_view_test
  import ecvt_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration write port
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_idx,
  input  logic [AXIS_W-1:0]            cfg_wdata,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_target_x,
  input  logic signed [COORD_BITS-1:0] in_target_y,
  input  logic signed [COORD_BITS-1:0] in_target_z,
  input  logic signed [COORD_BITS-1:0] in_sensor_x,
  input  logic signed [COORD_BITS-1:0] in_sensor_y,
  input  logic signed [COORD_BITS-1:0] in_sensor_z,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_in_view,
  output logic [2:0]                   out_verdict
);

  localparam int NAX    = 3;
  localparam int D_W    = COORD_BITS + 1;
  localparam int CMP_W  = (D_W > RANGE_W) ? D_W : RANGE_W;
  // once in range, every offset fits a signed range-wide word
  localparam int DT_W   = RANGE_W + 1;
  localparam int DSQ_W  = 2 * DT_W;
  localparam int DIST_W = DSQ_W + 2;
  localparam int PROD_W = DT_W + LANE_W;
  localparam int DOT_W  = PROD_W + 2;
  localparam int MAG_W  = PROD_W;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int HV_W   = SQ_W + TAN_W;
  localparam int RHS_W  = SQ_W + THTV_W;

  cfg_t               cfg;
  logic [PIPE_STAGES-1:0] en;
  logic [PIPE_STAGES-1:0] vld;

  logic signed [COORD_BITS-1:0] tgt [NAX];
  logic signed [COORD_BITS-1:0] sen [NAX];

  // stage 0: offsets
  logic signed [D_W-1:0]    d_r [NAX];
  logic signed [D_W-1:0]    d_nxt [NAX];
  // stage 1: per-axis range check, squares, axis products
  logic [D_W-1:0]           mag_full [NAX];
  logic signed [DT_W-1:0]   d_t [NAX];
  logic                     far_r, far_nxt;
  logic [DSQ_W-1:0]         sq_r [NAX];
  logic [DSQ_W-1:0]         sq_nxt [NAX];
  logic signed [PROD_W-1:0] pf_r [NAX];
  logic signed [PROD_W-1:0] pf_nxt [NAX];
  logic signed [PROD_W-1:0] ph_r [NAX];
  logic signed [PROD_W-1:0] ph_nxt [NAX];
  logic signed [PROD_W-1:0] pv_r [NAX];
  logic signed [PROD_W-1:0] pv_nxt [NAX];
  // stage 2: distance check, dot products
  logic [DIST_W-1:0]        dist_sq;
  logic                     oor_r, oor_nxt;
  logic signed [DOT_W-1:0]  dot_f_r, dot_f_nxt;
  logic signed [DOT_W-1:0]  dot_h_r, dot_h_nxt;
  logic signed [DOT_W-1:0]  dot_v_r, dot_v_nxt;
  // stage 3: behind check, magnitudes
  logic [MAG_W-1:0]         fm_r, hm_r, vm_r;
  flag_t                    flg_r [ST_MAG:ST_OUT-1];
  flag_t                    flg_nxt;
  // multiplier outputs
  logic [SQ_W-1:0]          f2, h2, v2;
  logic [HV_W-1:0]          hp, vp;
  logic [RHS_W-1:0]         fp;
  // output stage
  logic [RHS_W-1:0]         lhs;
  verdict_t                 verdict_r, verdict_nxt;
  logic                     view_r;

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [DOT_W-1:0] x);
    logic signed [DOT_W-1:0] neg;
    neg = -x;
    return x[DOT_W-1] ? MAG_W'(neg) : MAG_W'(x);
  endfunction

  ecvt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ecvt_pipe_ctl #(
    .NSTG (PIPE_STAGES)
  ) u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .en        (en),
    .vld       (vld)
  );

  assign tgt[0] = in_target_x;
  assign tgt[1] = in_target_y;
  assign tgt[2] = in_target_z;
  assign sen[0] = in_sensor_x;
  assign sen[1] = in_sensor_y;
  assign sen[2] = in_sensor_z;

  // Stage 0: target minus sensor, one bit wider
  always_comb begin
    for (int a = 0; a < NAX; a++) begin
      d_nxt[a] = D_W'(tgt[a]) - D_W'(sen[a]);
    end
  end

  // Stage 1: any axis beyond range, squares and axis lane products
  always_comb begin
    far_nxt = 1'b0;
    for (int a = 0; a < NAX; a++) begin
      mag_full[a] = d_r[a][D_W-1] ? D_W'(-d_r[a]) : D_W'(d_r[a]);
      far_nxt     = far_nxt || (CMP_W'(mag_full[a]) > CMP_W'(cfg.max_range));
      d_t[a]      = DT_W'(d_r[a]);
      sq_nxt[a]   = DSQ_W'(d_t[a]) * DSQ_W'(d_t[a]);
      pf_nxt[a]   = PROD_W'(d_t[a]) * PROD_W'(axis_lane(cfg.fwd, a));
      ph_nxt[a]   = PROD_W'(d_t[a]) * PROD_W'(axis_lane(cfg.rgt, a));
      pv_nxt[a]   = PROD_W'(d_t[a]) * PROD_W'(axis_lane(cfg.up, a));
    end
  end

  // Stage 2: squared distance against r^2, forward/right/up offsets
  always_comb begin
    dist_sq   = DIST_W'(sq_r[0]) + DIST_W'(sq_r[1]) + DIST_W'(sq_r[2]);
    oor_nxt   = far_r || (dist_sq > DIST_W'(cfg.r2));
    dot_f_nxt = DOT_W'(pf_r[0]) + DOT_W'(pf_r[1]) + DOT_W'(pf_r[2]);
    dot_h_nxt = DOT_W'(ph_r[0]) + DOT_W'(ph_r[1]) + DOT_W'(ph_r[2]);
    dot_v_nxt = DOT_W'(pv_r[0]) + DOT_W'(pv_r[1]) + DOT_W'(pv_r[2]);
  end

  // Stage 3: forward offset of zero or less is behind the sensor
  always_comb begin
    flg_nxt.oor    = oor_r;
    flg_nxt.behind = dot_f_r[DOT_W-1] || (dot_f_r == '0);
  end

  always_ff @(posedge clk) begin
    if (en[ST_DIFF]) begin
      d_r <= d_nxt;
    end
    if (en[ST_PROD]) begin
      far_r <= far_nxt;
      sq_r  <= sq_nxt;
      pf_r  <= pf_nxt;
      ph_r  <= ph_nxt;
      pv_r  <= pv_nxt;
    end
    if (en[ST_SUM]) begin
      oor_r   <= oor_nxt;
      dot_f_r <= dot_f_nxt;
      dot_h_r <= dot_h_nxt;
      dot_v_r <= dot_v_nxt;
    end
    if (en[ST_MAG]) begin
      fm_r          <= mag_of(dot_f_r);
      hm_r          <= mag_of(dot_h_r);
      vm_r          <= mag_of(dot_v_r);
      flg_r[ST_MAG] <= flg_nxt;
    end
    // early decisions ride alongside the multipliers
    for (int k = ST_MAG + 1; k < ST_OUT; k++) begin
      if (en[k]) begin
        flg_r[k] <= flg_r[k-1];
      end
    end
    if (en[ST_OUT]) begin
      verdict_r <= verdict_nxt;
      view_r    <= (verdict_nxt == VERDICT_INSIDE);
    end
  end

  // Squares of the three offsets
  ecvt_umul #(.AW(MAG_W), .BW(MAG_W)) u_sq_f (
    .clk (clk), .en (en[ST_SQ +: MUL_STG]), .a (fm_r), .b (fm_r), .p (f2)
  );
  ecvt_umul #(.AW(MAG_W), .BW(MAG_W)) u_sq_h (
    .clk (clk), .en (en[ST_SQ +: MUL_STG]), .a (hm_r), .b (hm_r), .p (h2)
  );
  ecvt_umul #(.AW(MAG_W), .BW(MAG_W)) u_sq_v (
    .clk (clk), .en (en[ST_SQ +: MUL_STG]), .a (vm_r), .b (vm_r), .p (v2)
  );

  // Scale by the tangents: h^2*tv, v^2*th, f^2*th*tv
  ecvt_umul #(.AW(SQ_W), .BW(TAN_W)) u_pr_h (
    .clk (clk), .en (en[ST_PR +: MUL_STG]), .a (h2), .b (cfg.tv), .p (hp)
  );
  ecvt_umul #(.AW(SQ_W), .BW(TAN_W)) u_pr_v (
    .clk (clk), .en (en[ST_PR +: MUL_STG]), .a (v2), .b (cfg.th), .p (vp)
  );
  ecvt_umul #(.AW(SQ_W), .BW(THTV_W)) u_pr_f (
    .clk (clk), .en (en[ST_PR +: MUL_STG]), .a (f2), .b (cfg.thtv), .p (fp)
  );

  // Output stage: checks in priority order, cone edge counts as inside
  always_comb begin
    lhs = (RHS_W'(hp) + RHS_W'(vp)) << TAN_FRAC;
    if (cfg.bad) begin
      verdict_nxt = VERDICT_INVALID;
    end else if (flg_r[ST_OUT-1].oor) begin
      verdict_nxt = VERDICT_RANGE;
    end else if (cfg.full) begin
      verdict_nxt = VERDICT_INSIDE;
    end else if (flg_r[ST_OUT-1].behind) begin
      verdict_nxt = VERDICT_BEHIND;
    end else if (lhs <= fp) begin
      verdict_nxt = VERDICT_INSIDE;
    end else begin
      verdict_nxt = VERDICT_CONE;
    end
  end

  assign out_valid   = vld[ST_OUT];
  assign out_in_view = view_r;
  assign out_verdict = verdict_r;

endmodule

@@ hw/rtl/ecvt_cfg.sv @@
// ----------------------------------------------------------------------------
// ecvt_cfg: configuration register file
// Holds the seven sensor registers and keeps r^2, th*tv and the invalid
// settings flag precomputed, each updated in the cycle after the raw registers.
// ----------------------------------------------------------------------------
module ecvt_cfg
  import ecvt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [AXIS_W-1:0]    cfg_wdata,
  output cfg_t                 cfg
);

  logic [AXIS_W-1:0]  fwd_r, fwd_nxt;
  logic [AXIS_W-1:0]  up_r, up_nxt;
  logic [AXIS_W-1:0]  rgt_r, rgt_nxt;
  logic [RANGE_W-1:0] range_r, range_nxt;
  logic [TAN_W-1:0]   th_r, th_nxt;
  logic [TAN_W-1:0]   tv_r, tv_nxt;
  logic               full_r, full_nxt;
  logic [R2_W-1:0]    r2_r, r2_nxt;
  logic [THTV_W-1:0]  thtv_r, thtv_nxt;
  logic               bad_r, bad_nxt;

  // Register writes
  always_comb begin
    fwd_nxt   = fwd_r;
    up_nxt    = up_r;
    rgt_nxt   = rgt_r;
    range_nxt = range_r;
    th_nxt    = th_r;
    tv_nxt    = tv_r;
    full_nxt  = full_r;
    if (cfg_we) begin
      case (cfg_idx)
        REG_FORWARD: fwd_nxt   = cfg_wdata;
        REG_UP:      up_nxt    = cfg_wdata;
        REG_RIGHT:   rgt_nxt   = cfg_wdata;
        REG_RANGE:   range_nxt = cfg_wdata[RANGE_W-1:0];
        REG_TAN_H:   th_nxt    = cfg_wdata[TAN_W-1:0];
        REG_TAN_V:   tv_nxt    = cfg_wdata[TAN_W-1:0];
        REG_FULL:    full_nxt  = cfg_wdata[0];
        default: begin
          // no register at this index
        end
      endcase
    end
  end

  // Precomputed terms, updated in the cycle after the raw registers
  always_comb begin
    r2_nxt   = R2_W'(range_r) * R2_W'(range_r);
    thtv_nxt = THTV_W'(th_r) * THTV_W'(tv_r);
    bad_nxt  = (range_r == '0) || (!full_r && ((th_r == '0) || (tv_r == '0)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r   <= FORWARD_RST;
      up_r    <= UP_RST;
      rgt_r   <= RIGHT_RST;
      range_r <= '0;
      th_r    <= TAN_ONE;
      tv_r    <= TAN_ONE;
      full_r  <= 1'b0;
      r2_r    <= '0;
      thtv_r  <= THTV_W'(TAN_ONE) * THTV_W'(TAN_ONE);
      bad_r   <= 1'b1;
    end else begin
      fwd_r   <= fwd_nxt;
      up_r    <= up_nxt;
      rgt_r   <= rgt_nxt;
      range_r <= range_nxt;
      th_r    <= th_nxt;
      tv_r    <= tv_nxt;
      full_r  <= full_nxt;
      r2_r    <= r2_nxt;
      thtv_r  <= thtv_nxt;
      bad_r   <= bad_nxt;
    end
  end

  assign cfg.fwd       = fwd_r;
  assign cfg.up        = up_r;
  assign cfg.rgt       = rgt_r;
  assign cfg.max_range = range_r;
  assign cfg.th        = th_r;
  assign cfg.tv        = tv_r;
  assign cfg.full      = full_r;
  assign cfg.r2        = r2_r;
  assign cfg.thtv      = thtv_r;
  assign cfg.bad       = bad_r;

endmodule

@@ hw/rtl/ecvt_umul.sv @@
// ----------------------------------------------------------------------------
// ecvt_umul: pipelined wide unsigned multiplier
// Splits both operands into 32-bit pieces: stage 0 forms the partial
// products, stage 1 sums each row, stage 2 sums the rows.
// ----------------------------------------------------------------------------
module ecvt_umul
  import ecvt_pkg::*;
#(
  parameter int AW = PIECE_W,
  parameter int BW = PIECE_W
) (
  input  logic               clk,
  input  logic [MUL_STG-1:0] en,
  input  logic [AW-1:0]      a,
  input  logic [BW-1:0]      b,
  output logic [AW+BW-1:0]   p
);

  localparam int NA    = (AW + PIECE_W - 1) / PIECE_W;
  localparam int NB    = (BW + PIECE_W - 1) / PIECE_W;
  localparam int PADA  = NA * PIECE_W;
  localparam int PADB  = NB * PIECE_W;
  localparam int PP_W  = 2 * PIECE_W;
  localparam int ROW_W = PADA + PIECE_W;
  localparam int ACC_W = PADA + PADB;

  logic [PADA-1:0]    a_pad;
  logic [PADB-1:0]    b_pad;
  logic [PP_W-1:0]    pp_r [NA][NB];
  logic [PP_W-1:0]    pp_nxt [NA][NB];
  logic [ROW_W-1:0]   row_r [NB];
  logic [ROW_W-1:0]   row_nxt [NB];
  logic [ACC_W-1:0]   acc;
  logic [AW+BW-1:0]   p_r, p_nxt;

  assign a_pad = PADA'(a);
  assign b_pad = PADB'(b);

  // Partial products, one 32x32 multiply each
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_nxt[i][j] = PP_W'(a_pad[i*PIECE_W +: PIECE_W]) * PP_W'(b_pad[j*PIECE_W +: PIECE_W]);
      end
    end
  end

  // Row sums over the pieces of a
  always_comb begin
    for (int j = 0; j < NB; j++) begin
      row_nxt[j] = '0;
      for (int i = 0; i < NA; i++) begin
        row_nxt[j] = row_nxt[j] + (ROW_W'(pp_r[i][j]) << (i * PIECE_W));
      end
    end
  end

  // Final sum over the pieces of b
  always_comb begin
    acc = '0;
    for (int j = 0; j < NB; j++) begin
      acc = acc + (ACC_W'(row_r[j]) << (j * PIECE_W));
    end
    p_nxt = acc[AW+BW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pp_r <= pp_nxt;
    end
    if (en[1]) begin
      row_r <= row_nxt;
    end
    if (en[2]) begin
      p_r <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

@@ hw/rtl/ecvt_pipe_ctl.sv @@
// ----------------------------------------------------------------------------
// ecvt_pipe_ctl: pipeline valid bits and stage load enables
// A stage loads when it is empty or the stage after it moves, so bubbles
// close up behind a stalled output word.
// ----------------------------------------------------------------------------
module ecvt_pipe_ctl
  import ecvt_pkg::*;
#(
  parameter int NSTG = PIPE_STAGES
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            out_stall,
  output logic            in_stall,
  output logic [NSTG-1:0] en,
  output logic [NSTG-1:0] vld
);

  logic [NSTG-1:0] vld_r, vld_nxt;
  logic [NSTG-1:0] hole;

  // Stage k may load if the output drains or any stage from k on is empty
  assign hole = ~vld_r;

  always_comb begin
    for (int k = 0; k < NSTG; k++) begin
      en[k] = !out_stall || (|(hole >> k));
    end
  end

  // Valid bits move with the data
  always_comb begin
    vld_nxt[0] = en[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NSTG; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign vld      = vld_r;
  assign in_stall = !en[0];

  // A completely full pipe behind a stalled output takes no word
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    ((&vld_r) && out_stall) |-> in_stall)
    else $error("input accepted into a full pipeline");

  // An empty first stage always takes a word
  a_room_taken: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[0] |-> !in_stall)
    else $error("input stalled with an empty first stage");

  // Word count rises by one when a word enters and none leaves
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !(vld_r[NSTG-1] && !out_stall))
    |=> ($countones(vld_r) == $past($countones(vld_r)) + 1))
    else $error("word lost or duplicated on entry");

  // Word count falls by one when a word leaves and none enters
  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    (!(in_valid && !in_stall) && vld_r[NSTG-1] && !out_stall)
    |=> ($countones(vld_r) + 1 == $past($countones(vld_r))))
    else $error("word lost or duplicated on exit");

endmodule
